>>> hw/rtl/integer_execute_unit_core_macros.svh
// Assertion macros shared by the checker files.
`ifndef INTEGER_EXECUTE_UNIT_CORE_MACROS_SVH
`define INTEGER_EXECUTE_UNIT_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define IEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/ieu_pkg.sv
// ---------------------------------------------------------------------------
// ieu_pkg
// Operation codes, widths and the decoded-transaction type of the execute unit.
// ---------------------------------------------------------------------------
package ieu_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActW    = 6;
  localparam int unsigned ImmW    = 16;
  localparam int unsigned JfW     = 28;
  localparam int unsigned ShW     = 5;
  localparam int unsigned QDepthDefault = 2;

  localparam logic [DataW-1:0] TopMask = 32'hF000_0000;

  typedef enum logic [ActW-1:0] {
    OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_AND = 6'd2, OP_DIV = 6'd3, OP_DIVU = 6'd4,
    OP_JALR = 6'd5, OP_JR = 6'd6, OP_MFHI = 6'd7, OP_MFLO = 6'd8, OP_MTHI = 6'd9,
    OP_MTLO = 6'd10, OP_MULT = 6'd11, OP_MULTU = 6'd12, OP_NOR = 6'd13,
    OP_OR = 6'd14, OP_SLL = 6'd15, OP_SLLV = 6'd16, OP_SLT = 6'd17,
    OP_SLTU = 6'd18, OP_SRA = 6'd19, OP_SRAV = 6'd20, OP_SRL = 6'd21,
    OP_SRLV = 6'd22, OP_SUB = 6'd23, OP_SUBU = 6'd24, OP_XOR = 6'd25,
    OP_ADDI = 6'd26, OP_ADDIU = 6'd27, OP_ANDI = 6'd28, OP_BEQ = 6'd29,
    OP_BGEZAL = 6'd30, OP_BGEZ = 6'd31, OP_BGTZ = 6'd32, OP_BLEZ = 6'd33,
    OP_BLTZ = 6'd34, OP_BLTZAL = 6'd35, OP_BNE = 6'd36, OP_LUI = 6'd37,
    OP_ORI = 6'd38, OP_SLTI = 6'd39, OP_SLTIU = 6'd40, OP_XORI = 6'd41,
    OP_J = 6'd42, OP_JAL = 6'd43
  } op_t;

  // Destination codes.
  localparam logic [1:0] DestNone = 2'd0;
  localparam logic [1:0] DestRd   = 2'd1;
  localparam logic [1:0] DestRt   = 2'd2;
  localparam logic [1:0] DestRa   = 2'd3;

  // Operation class chosen by the front end.
  typedef enum logic [2:0] {
    CL_SIMPLE = 3'd0, CL_MUL = 3'd1, CL_DIV = 3'd2, CL_HILO = 3'd3
  } cls_t;

  // One decoded transaction as it travels through the queue.
  typedef struct packed {
    cls_t             cls;
    logic             div_signed;
    logic             mul_signed;
    logic             rd_hi;
    logic             wr_hi;
    logic             wr_lo;
    logic [DataW-1:0] rs;
    logic [DataW-1:0] rt;
    logic [DataW-1:0] res;
    logic [1:0]       kind;
    logic [DataW-1:0] npc;
    logic             pcw;
  } dec_t;

endpackage

>>> hw/rtl/ieu_ram.sv
// ---------------------------------------------------------------------------
// ieu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ieu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ieu_front.sv
// ---------------------------------------------------------------------------
// ieu_front
// Decodes each transaction: computes all simple results and classifies
// multiply, divide and HI/LO work for the back end.
// ---------------------------------------------------------------------------
module ieu_front import ieu_pkg::*; (
  input  logic [ActW-1:0]  action,
  input  logic [DataW-1:0] rs_value,
  input  logic [DataW-1:0] rt_value,
  input  logic [ShW-1:0]   shift_amount,
  input  logic [ImmW-1:0]  immediate,
  input  logic [JfW-1:0]   jump_field,
  input  logic [DataW-1:0] pc_value,
  output dec_t             dec
);

  logic [DataW-1:0] imm_s, imm_z, btarget, jtarget, sum, diff;
  logic [ShW-1:0]   vsh;
  logic             rs_neg, rs_zero, take;

  assign imm_s   = {{(DataW-ImmW){immediate[ImmW-1]}}, immediate};
  assign imm_z   = {{(DataW-ImmW){1'b0}}, immediate};
  assign btarget = pc_value + {imm_s[DataW-3:0] - 30'd1, 2'b00};
  assign jtarget = (pc_value & TopMask) | {{(DataW-JfW){1'b0}}, jump_field};
  assign sum     = rs_value + rt_value;
  assign diff    = rs_value - rt_value;
  assign vsh     = rs_value[ShW-1:0];
  assign rs_neg  = rs_value[DataW-1];
  assign rs_zero = (rs_value == '0);

  // Decode and combinational execution.
  always_comb begin
    dec = '0;
    dec.cls = CL_SIMPLE;
    dec.rs = rs_value;
    dec.rt = rt_value;
    take = 1'b0;
    case (op_t'(action))
      OP_ADD, OP_ADDU: begin dec.res = sum; dec.kind = DestRd; end
      OP_AND:   begin dec.res = rs_value & rt_value; dec.kind = DestRd; end
      OP_DIV:   begin dec.cls = CL_DIV; dec.div_signed = 1'b1; end
      OP_DIVU:  begin dec.cls = CL_DIV; end
      OP_JALR: begin
        dec.res = pc_value; dec.kind = DestRd; dec.npc = rs_value; dec.pcw = 1'b1;
      end
      OP_JR:    begin dec.npc = rs_value; dec.pcw = 1'b1; end
      OP_MFHI:  begin dec.cls = CL_HILO; dec.rd_hi = 1'b1; dec.kind = DestRd; end
      OP_MFLO:  begin dec.cls = CL_HILO; dec.kind = DestRd; end
      OP_MTHI:  begin dec.cls = CL_HILO; dec.wr_hi = 1'b1; end
      OP_MTLO:  begin dec.cls = CL_HILO; dec.wr_lo = 1'b1; end
      OP_MULT:  begin dec.cls = CL_MUL; dec.mul_signed = 1'b1; end
      OP_MULTU: begin dec.cls = CL_MUL; end
      OP_NOR:   begin dec.res = ~(rs_value | rt_value); dec.kind = DestRd; end
      OP_OR:    begin dec.res = rs_value | rt_value; dec.kind = DestRd; end
      OP_SLL:   begin dec.res = rt_value << shift_amount; dec.kind = DestRd; end
      OP_SLLV:  begin dec.res = rt_value << vsh; dec.kind = DestRd; end
      OP_SLT: begin
        dec.res = {31'd0, $signed(rs_value) < $signed(rt_value)}; dec.kind = DestRd;
      end
      OP_SLTU:  begin dec.res = {31'd0, rs_value < rt_value}; dec.kind = DestRd; end
      OP_SRA: begin
        dec.res = DataW'($signed(rt_value) >>> shift_amount); dec.kind = DestRd;
      end
      OP_SRAV:  begin dec.res = DataW'($signed(rt_value) >>> vsh); dec.kind = DestRd; end
      OP_SRL:   begin dec.res = rt_value >> shift_amount; dec.kind = DestRd; end
      OP_SRLV:  begin dec.res = rt_value >> vsh; dec.kind = DestRd; end
      OP_SUB, OP_SUBU: begin dec.res = diff; dec.kind = DestRd; end
      OP_XOR:   begin dec.res = rs_value ^ rt_value; dec.kind = DestRd; end
      OP_ADDI, OP_ADDIU: begin dec.res = rs_value + imm_s; dec.kind = DestRt; end
      OP_ANDI:  begin dec.res = rs_value & imm_z; dec.kind = DestRt; end
      OP_BEQ:   take = (rs_value == rt_value);
      OP_BGEZAL: begin
        take = !rs_neg;
        if (take) begin dec.res = pc_value; dec.kind = DestRa; end
      end
      OP_BGEZ:  take = !rs_neg;
      OP_BGTZ:  take = !rs_neg && !rs_zero;
      OP_BLEZ:  take = rs_neg || rs_zero;
      OP_BLTZ:  take = rs_neg;
      OP_BLTZAL: begin
        take = rs_neg;
        if (take) begin dec.res = pc_value; dec.kind = DestRa; end
      end
      OP_BNE:   take = (rs_value != rt_value);
      OP_LUI:   begin dec.res = {jump_field[15:0], 16'd0}; dec.kind = DestRt; end
      OP_ORI:   begin dec.res = rs_value | imm_z; dec.kind = DestRt; end
      OP_SLTI: begin
        dec.res = {31'd0, $signed(rs_value) < $signed(imm_s)}; dec.kind = DestRt;
      end
      OP_SLTIU: begin dec.res = {31'd0, rs_value < imm_s}; dec.kind = DestRt; end
      OP_XORI:  begin dec.res = rs_value ^ imm_z; dec.kind = DestRt; end
      OP_J:     begin dec.npc = jtarget; dec.pcw = 1'b1; end
      OP_JAL: begin
        dec.res = pc_value; dec.kind = DestRa; dec.npc = jtarget; dec.pcw = 1'b1;
      end
      default: dec.cls = CL_SIMPLE;
    endcase
    if (take) begin
      dec.npc = btarget;
      dec.pcw = 1'b1;
    end
  end

endmodule

>>> hw/rtl/ieu_back.sv
// ---------------------------------------------------------------------------
// ieu_back
// Executes queued transactions: owns HI/LO, a 16x16 partial-product multiplier
// and a radix-2 divider, and drives the result strobe.
// ---------------------------------------------------------------------------
module ieu_back import ieu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  dec_t             q_data,
  output logic             q_pop,
  output logic             out_valid,
  output logic [DataW-1:0] out_result_value,
  output logic [1:0]       out_dest_kind,
  output logic [DataW-1:0] out_next_pc,
  output logic             out_pc_write,
  output logic             out_divide_by_zero
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_MUL = 4'b0010, ST_DIV = 4'b0100, ST_FIX = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  logic [DataW-1:0]   hi_r, lo_r;
  logic [DataW-1:0]   a_r, b_r;          // magnitudes
  logic [2*DataW-1:0] acc_r;             // product or {remainder, quotient}
  logic [1:0]         step_r;            // partial-product index
  logic [ShW:0]       cnt_r;             // divide bit counter
  logic               neg_q_r, neg_r_r, neg_p_r;
  logic [DataW-1:0]   qa, qb;
  logic               na, nb;
  logic [15:0]        pa, pb;
  logic [31:0]        pp_raw;
  logic [1:0]         pp_pos;
  logic [2*DataW-1:0] pp, prod;
  logic [DataW:0]     rem_sh, rem_sub;
  logic [DataW-1:0]   lo_fix, hi_fix;

  // Operand signs and magnitudes at dispatch.
  assign na = q_data.rs[DataW-1] & (q_data.mul_signed | q_data.div_signed);
  assign nb = q_data.rt[DataW-1] & (q_data.mul_signed | q_data.div_signed);
  assign qa = na ? (DataW'(0) - q_data.rs) : q_data.rs;
  assign qb = nb ? (DataW'(0) - q_data.rt) : q_data.rt;

  // One 16x16 partial product per cycle, shifted into place.
  assign pa = step_r[0] ? a_r[31:16] : a_r[15:0];
  assign pb = step_r[1] ? b_r[31:16] : b_r[15:0];
  assign pp_raw = pa * pb;
  assign pp_pos = {1'b0, step_r[0]} + {1'b0, step_r[1]};
  assign pp = {32'd0, pp_raw} << {pp_pos, 4'd0};
  assign prod = acc_r + pp;

  // One restoring divide step per cycle.
  assign rem_sh  = {acc_r[2*DataW-1:DataW], acc_r[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, b_r};

  // Sign correction after the iteration.
  assign lo_fix = neg_p_r ? ~acc_r[DataW-1:0] + 32'd1 :
                  neg_q_r ? DataW'(0) - acc_r[DataW-1:0] : acc_r[DataW-1:0];
  assign hi_fix = neg_p_r ? ~acc_r[2*DataW-1:DataW] + {31'd0, acc_r[DataW-1:0] == '0} :
                  neg_r_r ? DataW'(0) - acc_r[2*DataW-1:DataW] : acc_r[2*DataW-1:DataW];

  assign q_pop = (st_r == ST_IDLE) && q_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid && q_data.cls == CL_MUL) begin
          st_nxt = ST_MUL;
        end else if (q_valid && q_data.cls == CL_DIV && q_data.rt != '0) begin
          st_nxt = ST_DIV;
        end
      end
      ST_MUL:  if (step_r == 2'd3) st_nxt = ST_FIX;
      ST_DIV:  if (cnt_r == 6'd31) st_nxt = ST_FIX;
      ST_FIX:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      hi_r <= '0;
      lo_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= 1'b0;
      if (q_pop) begin
        out_valid <= (q_data.cls == CL_SIMPLE) || (q_data.cls == CL_HILO) ||
                     ((q_data.cls == CL_DIV) && (q_data.rt == '0));
        if (q_data.wr_hi) hi_r <= q_data.rs;
        if (q_data.wr_lo) lo_r <= q_data.rs;
      end
      if (st_r == ST_FIX) begin
        out_valid <= 1'b1;
        hi_r <= hi_fix;
        lo_r <= lo_fix;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        a_r <= qa;
        b_r <= qb;
        step_r <= 2'd0;
        cnt_r <= '0;
        neg_p_r <= (q_data.cls == CL_MUL) && (na != nb);
        neg_q_r <= (q_data.cls == CL_DIV) && (na != nb);
        neg_r_r <= (q_data.cls == CL_DIV) && na;
        acc_r <= (q_data.cls == CL_DIV) ? {32'd0, qa} : 64'd0;
        out_result_value <= q_data.res;
        out_dest_kind <= q_data.kind;
        out_next_pc <= q_data.npc;
        out_pc_write <= q_data.pcw;
        out_divide_by_zero <= (q_data.cls == CL_DIV) && (q_data.rt == '0);
        if (q_data.cls == CL_HILO && q_data.kind == DestRd) begin
          out_result_value <= q_data.rd_hi ? hi_r : lo_r;
        end
      end
      ST_MUL: begin
        acc_r <= prod;
        step_r <= step_r + 2'd1;
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (!rem_sub[DataW]) begin
          acc_r <= {rem_sub[DataW-1:0], acc_r[DataW-2:0], 1'b1};
        end else begin
          acc_r <= {rem_sh[DataW-1:0], acc_r[DataW-2:0], 1'b0};
        end
      end
      ST_FIX: begin
        out_result_value <= '0;
        out_dest_kind <= DestNone;
        out_next_pc <= '0;
        out_pc_write <= 1'b0;
        out_divide_by_zero <= 1'b0;
      end
      default: acc_r <= acc_r;
    endcase
  end

endmodule

>>> hw/rtl/ieu_queue.sv
// ---------------------------------------------------------------------------
// ieu_queue
// Short FIFO of decoded transactions between the front and back ends.
// ---------------------------------------------------------------------------
module ieu_queue import ieu_pkg::*; #(
  parameter int unsigned Depth = QDepthDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  dec_t wdata,
  input  logic pop,
  output logic valid,
  output logic full,
  output dec_t rdata
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic [AW-1:0] rp_nxt;
  logic [AW:0]   cnt_nxt;
  logic          rvalid_r;
  logic [$bits(dec_t)-1:0] rbits;

  assign rp_nxt  = (pop && rvalid_r) ? ((rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1) : rp_r;
  assign cnt_nxt = cnt_r + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop && rvalid_r};
  assign full    = (cnt_r == (AW+1)'(Depth));
  assign valid   = rvalid_r;
  assign rdata   = dec_t'(rbits);

  // Storage, read address runs one ahead so data is ready when valid.
  ieu_ram #(.Width($bits(dec_t)), .Depth(1 << AW)) u_ram (
    .clk(clk), .we(push), .waddr(wp_r), .wdata(wdata),
    .raddr(rp_nxt), .rdata(rbits)
  );

  // Pointers and occupancy; valid follows a write through cnt_r and then rvalid_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
      rvalid_r <= (cnt_r - {{AW{1'b0}}, pop && rvalid_r}) != '0;
    end
  end

endmodule

>>> hw/rtl/integer_execute_unit_core.sv
// ---------------------------------------------------------------------------
// integer_execute_unit_core
// 32-bit integer execute unit with HI/LO, multiply and divide.
// ---------------------------------------------------------------------------
// Channel   Ports               Handshake
// input     start, in_*         accepted when start && !busy
// result    out_valid, out_*    one-cycle strobe, no back pressure
// Simple operations and HI/LO moves pass through the queue RAM, its valid flag
// and the back-end result registers. Multiply forms four 16x16 partial products;
// divide forms one quotient bit per cycle. busy rises while the queue is full.
// Synchronous active-low reset clears HI, LO, the queue and the back-end control state.
// ---------------------------------------------------------------------------
module integer_execute_unit_core import ieu_pkg::*; #(
  parameter int unsigned QDepth = QDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ActW-1:0]   in_action,
  input  logic [DataW-1:0]  in_rs_value,
  input  logic [DataW-1:0]  in_rt_value,
  input  logic [ShW-1:0]    in_shift_amount,
  input  logic [ImmW-1:0]   in_immediate,
  input  logic [JfW-1:0]    in_jump_field,
  input  logic [DataW-1:0]  in_pc_value,
  output logic              out_valid,
  output logic [DataW-1:0]  out_result_value,
  output logic [1:0]        out_dest_kind,
  output logic [DataW-1:0]  out_next_pc,
  output logic              out_pc_write,
  output logic              out_divide_by_zero
);

  dec_t dec, q_data;
  logic q_full, q_valid, q_pop, push;

  assign push = start && !busy;
  assign busy = q_full;

  ieu_front u_front (
    .action(in_action), .rs_value(in_rs_value), .rt_value(in_rt_value),
    .shift_amount(in_shift_amount), .immediate(in_immediate),
    .jump_field(in_jump_field), .pc_value(in_pc_value), .dec(dec)
  );

  ieu_queue #(.Depth(QDepth)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(dec), .pop(q_pop),
    .valid(q_valid), .full(q_full), .rdata(q_data)
  );

  ieu_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_dest_kind(out_dest_kind), .out_next_pc(out_next_pc),
    .out_pc_write(out_pc_write), .out_divide_by_zero(out_divide_by_zero)
  );

endmodule

>>> hw/rtl/ieu_checker.sv
// ---------------------------------------------------------------------------
// ieu_checker
// Port-level checks on the execute unit's result channel.
// ---------------------------------------------------------------------------
`include "integer_execute_unit_core_macros.svh"
module ieu_checker import ieu_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [DataW-1:0] out_result_value,
  input logic [1:0]       out_dest_kind,
  input logic [DataW-1:0] out_next_pc,
  input logic             out_pc_write,
  input logic             out_divide_by_zero
);

  // The unit can only become busy after accepting a transaction.
  `IEU_ASSERT_NEXT(a_busy_needs_accept, clk, rst_n, !busy && !start, !busy, "busy without accept")
  // A zero divisor never comes with a destination or a new PC.
  `IEU_ASSERT_IMP(a_dz_quiet, clk, rst_n, out_valid && out_divide_by_zero, out_dest_kind == DestNone && !out_pc_write, "divide by zero with side effect")
  // No result without a destination carries a value.
  `IEU_ASSERT_IMP(a_res_zero, clk, rst_n, out_valid && out_dest_kind == DestNone, out_result_value == '0, "result without destination")
  // No new PC without pc_write.
  `IEU_ASSERT_IMP(a_npc_zero, clk, rst_n, out_valid && !out_pc_write, out_next_pc == '0, "next_pc without pc_write")

endmodule

bind integer_execute_unit_core ieu_checker u_ieu_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_result_value(out_result_value), .out_dest_kind(out_dest_kind),
  .out_next_pc(out_next_pc), .out_pc_write(out_pc_write),
  .out_divide_by_zero(out_divide_by_zero)
);
